// ----- rtl/msea_pkg.sv -----
package msea_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  dbytes_t;
  typedef logic [1:0]  mod_t;
  typedef logic [2:0]  rm_t;

  localparam mod_t MOD_NODISP = 2'd0;
  localparam mod_t MOD_DISP8  = 2'd1;
  localparam mod_t MOD_DISPW  = 2'd2;
  localparam mod_t MOD_REG    = 2'd3;

  localparam rm_t RM_SIB      = 3'b100;
  localparam rm_t RM_DIRECT32 = 3'b101;
  localparam rm_t RM_DIRECT16 = 3'b110;
  localparam rm_t INDEX_NONE  = 3'b100;

  localparam dbytes_t DBYTES_0 = 3'd0;
  localparam dbytes_t DBYTES_1 = 3'd1;
  localparam dbytes_t DBYTES_2 = 3'd2;
  localparam dbytes_t DBYTES_4 = 3'd4;

  typedef struct packed {
    logic    register_operand;
    logic    sib_present;
    dbytes_t disp_bytes;
    logic    wrap16;
  } flags_t;

endpackage

// ----- rtl/msea_item_if.sv -----
interface msea_item_if;
  logic            valid;
  logic            ready;
  msea_pkg::byte_t modrm;
  msea_pkg::byte_t sib;
  msea_pkg::word_t disp;
  logic            addr32;
  msea_pkg::word_t reg_eax;
  msea_pkg::word_t reg_ecx;
  msea_pkg::word_t reg_edx;
  msea_pkg::word_t reg_ebx;
  msea_pkg::word_t reg_esp;
  msea_pkg::word_t reg_ebp;
  msea_pkg::word_t reg_esi;
  msea_pkg::word_t reg_edi;

  modport source (
    output valid, modrm, sib, disp, addr32,
    output reg_eax, reg_ecx, reg_edx, reg_ebx, reg_esp, reg_ebp, reg_esi, reg_edi,
    input  ready
  );

  modport sink (
    input  valid, modrm, sib, disp, addr32,
    input  reg_eax, reg_ecx, reg_edx, reg_ebx, reg_esp, reg_ebp, reg_esi, reg_edi,
    output ready
  );
endinterface

// ----- rtl/msea_result_if.sv -----
interface msea_result_if;
  logic              valid;
  logic              ready;
  msea_pkg::word_t   address;
  logic              register_operand;
  msea_pkg::dbytes_t disp_bytes;
  logic              sib_present;

  modport source (
    output valid, address, register_operand, disp_bytes, sib_present,
    input  ready
  );

  modport sink (
    input  valid, address, register_operand, disp_bytes, sib_present,
    output ready
  );
endinterface

// ----- rtl/modrm_sib_effective_address_core.sv -----
// channel   role    payload
// item      sink    modrm, sib, disp, addr32, reg_eax .. reg_edi
// result    source  address, register_operand, disp_bytes, sib_present
//
// An accepted item beat passes the stage one, two and three registers to its result beat.
// One item per cycle while the result side does not stall: decode and operand select, base
// plus index add, then displacement add and 16-bit wrap, each behind its own register stage.
// Synchronous reset clears the stage valid bits only.
// A stage holds while the one after it is full and stalled; bubbles close up.
module modrm_sib_effective_address_core (
  input logic          clk,
  input logic          rst,
  msea_item_if.sink    item,
  msea_result_if.source result
);

  msea_pkg::word_t regs [8];
  msea_pkg::mod_t  mod;
  msea_pkg::rm_t   rm;
  msea_pkg::rm_t   sib_base;
  msea_pkg::rm_t   sib_index;
  logic [1:0]      sib_scale;
  msea_pkg::word_t disp8;
  msea_pkg::word_t disp16;

  msea_pkg::word_t base_next;
  msea_pkg::word_t index_next;
  msea_pkg::word_t disp_next;
  msea_pkg::flags_t flags_next;
  logic            no_base;

  logic             v1, v2, v3;
  logic             ready1, ready2, ready3;
  msea_pkg::word_t  s1_base, s1_index, s1_disp;
  msea_pkg::flags_t s1_flags;
  msea_pkg::word_t  s2_sum, s2_disp;
  msea_pkg::flags_t s2_flags;
  msea_pkg::word_t  s3_address;
  msea_pkg::flags_t s3_flags;
  msea_pkg::word_t  sum_next;

  assign regs[0] = item.reg_eax;
  assign regs[1] = item.reg_ecx;
  assign regs[2] = item.reg_edx;
  assign regs[3] = item.reg_ebx;
  assign regs[4] = item.reg_esp;
  assign regs[5] = item.reg_ebp;
  assign regs[6] = item.reg_esi;
  assign regs[7] = item.reg_edi;

  assign mod       = item.modrm[7:6];
  assign rm        = item.modrm[2:0];
  assign sib_scale = item.sib[7:6];
  assign sib_index = item.sib[5:3];
  assign sib_base  = item.sib[2:0];
  assign disp8     = {{24{item.disp[7]}}, item.disp[7:0]};
  assign disp16    = {16'b0, item.disp[15:0]};

  assign ready3     = !v3 || result.ready;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign item.ready = ready1;

  always_comb begin
    base_next  = '0;
    index_next = '0;
    disp_next  = '0;
    flags_next = '0;
    no_base    = 1'b0;
    if (mod == msea_pkg::MOD_REG) begin
      flags_next.register_operand = 1'b1;
    end else if (!item.addr32) begin
      flags_next.wrap16 = 1'b1;
      case (rm)
        3'd0: begin
          base_next  = {16'b0, regs[3][15:0]};
          index_next = {16'b0, regs[6][15:0]};
        end
        3'd1: begin
          base_next  = {16'b0, regs[3][15:0]};
          index_next = {16'b0, regs[7][15:0]};
        end
        3'd2: begin
          base_next  = {16'b0, regs[5][15:0]};
          index_next = {16'b0, regs[6][15:0]};
        end
        3'd3: begin
          base_next  = {16'b0, regs[5][15:0]};
          index_next = {16'b0, regs[7][15:0]};
        end
        3'd4: begin
          base_next = {16'b0, regs[6][15:0]};
        end
        3'd5: begin
          base_next = {16'b0, regs[7][15:0]};
        end
        3'd6: begin
          base_next = (mod == msea_pkg::MOD_NODISP) ? '0 : {16'b0, regs[5][15:0]};
        end
        default: begin
          base_next = {16'b0, regs[3][15:0]};
        end
      endcase
      if (mod == msea_pkg::MOD_DISP8) begin
        disp_next             = disp8;
        flags_next.disp_bytes = msea_pkg::DBYTES_1;
      end else if (mod == msea_pkg::MOD_DISPW || rm == msea_pkg::RM_DIRECT16) begin
        disp_next             = disp16;
        flags_next.disp_bytes = msea_pkg::DBYTES_2;
      end
    end else begin
      if (rm == msea_pkg::RM_SIB) begin
        flags_next.sib_present = 1'b1;
        if (sib_base == msea_pkg::RM_DIRECT32 && mod == msea_pkg::MOD_NODISP) begin
          no_base = 1'b1;
        end else begin
          base_next = regs[sib_base];
        end
        if (sib_index != msea_pkg::INDEX_NONE) begin
          index_next = regs[sib_index] << sib_scale;
        end
      end else if (rm == msea_pkg::RM_DIRECT32 && mod == msea_pkg::MOD_NODISP) begin
        no_base = 1'b1;
      end else begin
        base_next = regs[rm];
      end
      if (mod == msea_pkg::MOD_DISP8) begin
        disp_next             = disp8;
        flags_next.disp_bytes = msea_pkg::DBYTES_1;
      end else if (mod == msea_pkg::MOD_DISPW || no_base) begin
        disp_next             = item.disp;
        flags_next.disp_bytes = msea_pkg::DBYTES_4;
      end
    end
  end

  assign sum_next = s2_sum + s2_disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= item.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && item.valid) begin
      s1_base  <= base_next;
      s1_index <= index_next;
      s1_disp  <= disp_next;
      s1_flags <= flags_next;
    end
    if (ready2 && v1) begin
      s2_sum   <= s1_base + s1_index;
      s2_disp  <= s1_disp;
      s2_flags <= s1_flags;
    end
    if (ready3 && v2) begin
      s3_address <= s2_flags.wrap16 ? {16'b0, sum_next[15:0]} : sum_next;
      s3_flags   <= s2_flags;
    end
  end

  assign result.valid            = v3;
  assign result.address          = s3_address;
  assign result.register_operand = s3_flags.register_operand;
  assign result.disp_bytes       = s3_flags.disp_bytes;
  assign result.sib_present      = s3_flags.sib_present;

`ifndef ASSERT_OFF
  a_regop_clean: assert property (@(posedge clk) disable iff (rst)
    v3 && s3_flags.register_operand |->
      s3_address == '0 && s3_flags.disp_bytes == msea_pkg::DBYTES_0 && !s3_flags.sib_present)
    else $error("register operand carries address or displacement");

  a_wrap16: assert property (@(posedge clk) disable iff (rst)
    v3 && s3_flags.wrap16 |-> s3_address[31:16] == 16'b0 && !s3_flags.sib_present)
    else $error("16-bit address exceeds 64K or flags a SIB byte");

  a_dbytes: assert property (@(posedge clk) disable iff (rst)
    v3 |-> s3_flags.disp_bytes == msea_pkg::DBYTES_0 || s3_flags.disp_bytes == msea_pkg::DBYTES_1
        || s3_flags.disp_bytes == msea_pkg::DBYTES_2 || s3_flags.disp_bytes == msea_pkg::DBYTES_4)
    else $error("illegal displacement length");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && ready3 |=> v3 && s3_flags == $past(s2_flags))
    else $error("stage two beat lost on advance");
`endif

endmodule

// ----- verif/tb_modrm_sib_effective_address_core.sv -----
`timescale 1ns / 1ps

module tb_modrm_sib_effective_address_core;

  localparam int unsigned PIPE_DEPTH   = 3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 300;

  localparam msea_pkg::rm_t REG_EAX = 3'd0;
  localparam msea_pkg::rm_t REG_ECX = 3'd1;
  localparam msea_pkg::rm_t REG_EDX = 3'd2;
  localparam msea_pkg::rm_t REG_EBX = 3'd3;
  localparam msea_pkg::rm_t REG_ESP = 3'd4;
  localparam msea_pkg::rm_t REG_EBP = 3'd5;
  localparam msea_pkg::rm_t REG_ESI = 3'd6;
  localparam msea_pkg::rm_t REG_EDI = 3'd7;

  localparam msea_pkg::rm_t RM16_BX_SI = 3'd0;
  localparam msea_pkg::rm_t RM16_BX_DI = 3'd1;
  localparam msea_pkg::rm_t RM16_BP_SI = 3'd2;
  localparam msea_pkg::rm_t RM16_BP_DI = 3'd3;
  localparam msea_pkg::rm_t RM16_SI    = 3'd4;
  localparam msea_pkg::rm_t RM16_DI    = 3'd5;
  localparam msea_pkg::rm_t RM16_BX    = 3'd7;

  typedef struct packed {
    msea_pkg::byte_t       modrm;
    msea_pkg::byte_t       sib;
    msea_pkg::word_t       disp;
    logic                  addr32;
    msea_pkg::word_t [7:0] gpr;
  } ea_operands_t;

  typedef struct packed {
    msea_pkg::word_t   address;
    logic              register_operand;
    msea_pkg::dbytes_t disp_bytes;
    logic              sib_present;
  } ea_result_t;

  logic clk;
  logic rst;

  msea_item_if   item_ch();
  msea_result_if result_ch();

  modrm_sib_effective_address_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ea_result_t  expected_ea_q[$];
  int unsigned err_count   = 0;
  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  int unsigned rx_hold_req = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic msea_pkg::word_t rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic ea_operands_t rand_operands();
    ea_operands_t op;
    op.modrm  = 8'($urandom_range(0, 255));
    op.sib    = 8'($urandom_range(0, 255));
    op.disp   = rand_word();
    op.addr32 = 1'($urandom_range(0, 1));
    for (int i = 0; i < 8; i++) begin
      op.gpr[i] = rand_word();
    end
    return op;
  endfunction

  function automatic ea_result_t compute_effective_address(ea_operands_t op);
    ea_result_t      res;
    msea_pkg::mod_t  md;
    msea_pkg::rm_t   rm;
    msea_pkg::rm_t   idx;
    msea_pkg::rm_t   bsel;
    logic [1:0]      ss;
    logic [15:0]     base16;
    logic [15:0]     d16;
    msea_pkg::word_t base32;
    msea_pkg::word_t d32;
    logic            no_base;
    res     = '0;
    md      = op.modrm[7:6];
    rm      = op.modrm[2:0];
    base16  = '0;
    d16     = '0;
    base32  = '0;
    d32     = '0;
    no_base = 1'b0;
    if (md == msea_pkg::MOD_REG) begin
      res.register_operand = 1'b1;
    end else if (!op.addr32) begin
      case (rm)
        RM16_BX_SI: base16 = op.gpr[REG_EBX][15:0] + op.gpr[REG_ESI][15:0];
        RM16_BX_DI: base16 = op.gpr[REG_EBX][15:0] + op.gpr[REG_EDI][15:0];
        RM16_BP_SI: base16 = op.gpr[REG_EBP][15:0] + op.gpr[REG_ESI][15:0];
        RM16_BP_DI: base16 = op.gpr[REG_EBP][15:0] + op.gpr[REG_EDI][15:0];
        RM16_SI:    base16 = op.gpr[REG_ESI][15:0];
        RM16_DI:    base16 = op.gpr[REG_EDI][15:0];
        msea_pkg::RM_DIRECT16:
          base16 = (md == msea_pkg::MOD_NODISP) ? 16'h0000 : op.gpr[REG_EBP][15:0];
        default:    base16 = op.gpr[REG_EBX][15:0];
      endcase
      if (md == msea_pkg::MOD_DISP8) begin
        d16            = {{8{op.disp[7]}}, op.disp[7:0]};
        res.disp_bytes = msea_pkg::DBYTES_1;
      end else if (md == msea_pkg::MOD_DISPW || rm == msea_pkg::RM_DIRECT16) begin
        d16            = op.disp[15:0];
        res.disp_bytes = msea_pkg::DBYTES_2;
      end
      res.address = {16'h0000, 16'(base16 + d16)};
    end else begin
      if (rm == msea_pkg::RM_SIB) begin
        ss              = op.sib[7:6];
        idx             = op.sib[5:3];
        bsel            = op.sib[2:0];
        res.sib_present = 1'b1;
        if (bsel == msea_pkg::RM_DIRECT32 && md == msea_pkg::MOD_NODISP) begin
          no_base = 1'b1;
        end else begin
          base32 = op.gpr[bsel];
        end
        if (idx != msea_pkg::INDEX_NONE) begin
          base32 = base32 + (op.gpr[idx] << ss);
        end
      end else if (rm == msea_pkg::RM_DIRECT32 && md == msea_pkg::MOD_NODISP) begin
        no_base = 1'b1;
      end else begin
        base32 = op.gpr[rm];
      end
      if (md == msea_pkg::MOD_DISP8) begin
        d32            = {{24{op.disp[7]}}, op.disp[7:0]};
        res.disp_bytes = msea_pkg::DBYTES_1;
      end else if (md == msea_pkg::MOD_DISPW || no_base) begin
        d32            = op.disp;
        res.disp_bytes = msea_pkg::DBYTES_4;
      end
      res.address = base32 + d32;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, msea_pkg::word_t got, msea_pkg::word_t want);
    $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    err_count++;
  endtask

  // Hold valid across back-to-back beats; drop it only for a gap.
  task automatic send_operands(ea_operands_t op);
    item_ch.valid   <= 1'b1;
    item_ch.modrm   <= op.modrm;
    item_ch.sib     <= op.sib;
    item_ch.disp    <= op.disp;
    item_ch.addr32  <= op.addr32;
    item_ch.reg_eax <= op.gpr[REG_EAX];
    item_ch.reg_ecx <= op.gpr[REG_ECX];
    item_ch.reg_edx <= op.gpr[REG_EDX];
    item_ch.reg_ebx <= op.gpr[REG_EBX];
    item_ch.reg_esp <= op.gpr[REG_ESP];
    item_ch.reg_ebp <= op.gpr[REG_EBP];
    item_ch.reg_esi <= op.gpr[REG_ESI];
    item_ch.reg_edi <= op.gpr[REG_EDI];
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    expected_ea_q.push_back(compute_effective_address(op));
    if (tx_idle_on && $urandom_range(0, 99) < 25) begin
      item_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (expected_ea_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    ea_operands_t op;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < 2; k++) begin
      op        = rand_operands();
      op.addr32 = k[0];
      op.modrm  = {msea_pkg::MOD_REG, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
      send_operands(op);
    end
    // negative disp8 with junk in the upper bits, every 16-bit rm
    for (int k = 0; k < 8; k++) begin
      op        = rand_operands();
      op.addr32 = 1'b0;
      op.modrm  = {msea_pkg::MOD_DISP8, 3'($urandom_range(0, 7)), 3'(k)};
      op.disp   = 32'hABCD_EF80;
      send_operands(op);
    end
    op        = rand_operands();
    op.addr32 = 1'b0;
    op.modrm  = {msea_pkg::MOD_NODISP, 3'd0, msea_pkg::RM_DIRECT16};
    op.disp   = 32'hFFFF_FFFF;
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b0;
    op.modrm  = {msea_pkg::MOD_DISPW, 3'd7, RM16_BX_SI};
    op.disp   = 32'hFFFF_FFFF;
    for (int i = 0; i < 8; i++) op.gpr[i] = 32'hFFFF_FFFF;
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_NODISP, 3'd2, msea_pkg::RM_DIRECT32};
    op.disp   = 32'hFFFF_FFFF;
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_NODISP, 3'd0, msea_pkg::RM_SIB};
    op.sib    = {2'd3, msea_pkg::INDEX_NONE, msea_pkg::RM_DIRECT32};
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_DISP8, 3'd4, msea_pkg::RM_SIB};
    op.sib    = {2'd1, REG_ECX, REG_EBP};
    op.disp   = 32'h0000_007F;
    send_operands(op);
    for (int k = 0; k < 4; k++) begin
      op        = rand_operands();
      op.addr32 = 1'b1;
      op.modrm  = {msea_pkg::MOD_NODISP, 3'd5, msea_pkg::RM_SIB};
      op.sib    = {2'(k), REG_ESI, REG_EBX};
      send_operands(op);
    end
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_DISPW, 3'd1, REG_EAX};
    op.disp   = 32'hFFFF_FFFF;
    for (int i = 0; i < 8; i++) op.gpr[i] = 32'hFFFF_FFFF;
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_NODISP, 3'd0, REG_EDI};
    op.disp   = 32'h0000_0000;
    for (int i = 0; i < 8; i++) op.gpr[i] = 32'h0000_0000;
    send_operands(op);
    op        = rand_operands();
    op.addr32 = 1'b1;
    op.modrm  = {msea_pkg::MOD_DISP8, 3'd0, REG_ESP};
    op.disp   = 32'h0000_0080;
    send_operands(op);
  endtask

  task automatic test_random_traffic(int unsigned count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (count) send_operands(rand_operands());
  endtask

  task automatic test_full_rate_burst(int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_operands(rand_operands());
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills.
  task automatic test_backpressure_fill();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b1;
    rx_hold_req = LONG_HOLD;
    repeat (40) send_operands(rand_operands());
    item_ch.valid <= 1'b0;
    wait_for_drain();
  endtask

  task automatic test_pause_for_drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    for (int k = 0; k < 6; k++) begin
      repeat ($urandom_range(5, 15)) send_operands(rand_operands());
      item_ch.valid <= 1'b0;
      wait_for_drain();
      @(posedge clk);
    end
  endtask

  initial begin : result_sink
    ea_result_t  want;
    int unsigned stall_left;
    logic        next_ready;
    stall_left      = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (expected_ea_q.size() == 0) begin
          report_mismatch("unexpected result beat", result_ch.address, '0);
        end else begin
          want = expected_ea_q.pop_front();
          if (result_ch.address !== want.address)
            report_mismatch("address", result_ch.address, want.address);
          if (result_ch.register_operand !== want.register_operand)
            report_mismatch("register_operand", 32'(result_ch.register_operand),
                            32'(want.register_operand));
          if (result_ch.disp_bytes !== want.disp_bytes)
            report_mismatch("disp_bytes", 32'(result_ch.disp_bytes), 32'(want.disp_bytes));
          if (result_ch.sib_present !== want.sib_present)
            report_mismatch("sib_present", 32'(result_ch.sib_present),
                            32'(want.sib_present));
        end
      end
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rst) begin
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        next_ready = 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      result_ch.ready <= next_ready;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst             <= 1'b1;
    item_ch.valid   <= 1'b0;
    item_ch.modrm   <= '0;
    item_ch.sib     <= '0;
    item_ch.disp    <= '0;
    item_ch.addr32  <= 1'b0;
    item_ch.reg_eax <= '0;
    item_ch.reg_ecx <= '0;
    item_ch.reg_edx <= '0;
    item_ch.reg_ebx <= '0;
    item_ch.reg_esp <= '0;
    item_ch.reg_ebp <= '0;
    item_ch.reg_esi <= '0;
    item_ch.reg_edi <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_random_traffic(600);
    test_full_rate_burst(200);
    test_backpressure_fill();
    test_pause_for_drain();
    test_random_traffic(680);
    item_ch.valid <= 1'b0;
    wait_for_drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (err_count == 0 && expected_ea_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msea_pkg.sv
rtl/msea_item_if.sv
rtl/msea_result_if.sv
rtl/modrm_sib_effective_address_core.sv
verif/tb_modrm_sib_effective_address_core.sv
